### rtl/assert_macros.svh
// assertion macros used by the entry store of the threshold filter and sorter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TFDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define TFDS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

### rtl/tfds_pkg.sv
// package with the shared types and constants of the threshold filter and sorter
package tfds_pkg;

    localparam int unsigned LIMIT_BITS = 16;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd200;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PLACE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic valid;
        logic keep;
        logic last;
    } t_in_ctl;

    typedef struct packed {
        logic valid;
        logic entry_valid;
        logic overflowed;
        logic end_of_list;
    } t_out_stat;

endpackage

### rtl/tfds_store.sv
// entry store with insertion sort in a one-port-write, one-port-read memory and sorted readout
`include "assert_macros.svh"

module tfds_store import tfds_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned INDEX_BITS  = 8,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_ctl               i_ctl,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [INDEX_BITS-1:0] i_row,
    input  logic [INDEX_BITS-1:0] i_col,
    output logic                  o_in_stall,
    input  logic                  i_out_stall,
    output t_out_stat             o_stat,
    output logic [COUNT_BITS-1:0] o_count,
    output logic [INDEX_BITS-1:0] o_row,
    output logic [INDEX_BITS-1:0] o_col
);

    localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
    } t_entry;

    t_entry mem [MAX_ENTRIES];

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_ovf, n_ovf;
    logic             r_final, n_final;
    t_entry           r_new, n_new;
    t_entry           r_rd_data;
    logic             r_out_valid, n_out_valid;
    logic             r_out_entry, n_out_entry;
    logic             r_out_ovf, n_out_ovf;
    logic             r_out_last, n_out_last;

    logic              accept;
    logic              out_free;
    logic              shift;
    logic              load;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_entry            in_entry;
    logic [CNT_W-1:0]  total_m1;
    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  pos_m2;
    logic [CNT_W-1:0]  ptr_p1;

    assign in_entry = '{count: i_count, row: i_row, col: i_col};
    assign total_m1 = r_total - ONE_CNT;
    assign pos_m1   = r_pos - ONE_CNT;
    assign pos_m2   = r_pos - CNT_W'(2);
    assign ptr_p1   = r_ptr + ONE_CNT;
    assign out_free = !r_out_valid || !i_out_stall;
    assign shift    = r_rd_data.count < r_new.count;

    // an item needing the read port or the output register waits for the pending result
    assign o_in_stall = (r_state != ST_IDLE)
                     || (r_out_valid && ((r_total != '0) || i_ctl.last));
    assign accept     = i_ctl.valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_ctl.keep && (r_total != MAX_CNT) && (r_total != '0)) begin
                        n_state = ST_INSERT;
                    end else if (i_ctl.last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_INSERT: begin
                if (shift) begin
                    if (r_pos == ONE_CNT) begin
                        n_state = ST_PLACE;
                    end
                end else begin
                    n_state = r_final ? ST_EMIT : ST_IDLE;
                end
            end
            ST_PLACE: begin
                n_state = r_final ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free && ((r_total == '0) || (ptr_p1 == r_total))) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = r_new;
        rd_en       = 1'b0;
        rd_addr     = '0;
        load        = 1'b0;
        n_total     = r_total;
        n_pos       = r_pos;
        n_ptr       = r_ptr;
        n_ovf       = r_ovf;
        n_final     = r_final;
        n_new       = r_new;
        n_out_entry = r_out_entry;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_final = i_ctl.last;
                    n_new   = in_entry;
                    if (i_ctl.keep) begin
                        if (r_total == MAX_CNT) begin
                            n_ovf = 1'b1;
                        end else if (r_total == '0) begin
                            wr_en   = 1'b1;
                            wr_data = in_entry;
                            n_total = ONE_CNT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = total_m1[ADDR_W-1:0];
                            n_pos   = r_total;
                        end
                    end
                end
            end
            ST_INSERT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[ADDR_W-1:0];
                if (shift) begin
                    // read two below the write, so the same entry is never hit
                    wr_data = r_rd_data;
                    n_pos   = pos_m1;
                    if (r_pos != ONE_CNT) begin
                        rd_en   = 1'b1;
                        rd_addr = pos_m2[ADDR_W-1:0];
                    end
                end else begin
                    n_total = r_total + ONE_CNT;
                end
            end
            ST_PLACE: begin
                wr_en   = 1'b1;
                n_total = r_total + ONE_CNT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    load = 1'b1;
                    if (r_total == '0) begin
                        n_out_entry = 1'b0;
                        n_out_ovf   = 1'b0;
                        n_out_last  = 1'b1;
                        n_ovf       = 1'b0;
                    end else begin
                        rd_en       = 1'b1;
                        rd_addr     = r_ptr[ADDR_W-1:0];
                        n_out_entry = 1'b1;
                        n_out_ovf   = r_ovf;
                        n_out_last  = (ptr_p1 == r_total);
                        n_ptr       = ptr_p1;
                        if (ptr_p1 == r_total) begin
                            n_total = '0;
                            n_ovf   = 1'b0;
                            n_ptr   = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_out_valid = load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_ptr       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_ptr       <= n_ptr;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_final     <= n_final;
        r_new       <= n_new;
        r_out_entry <= n_out_entry;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign o_stat  = '{valid: r_out_valid, entry_valid: r_out_entry,
                       overflowed: r_out_ovf, end_of_list: r_out_last};
    assign o_count = r_rd_data.count;
    assign o_row   = r_rd_data.row;
    assign o_col   = r_rd_data.col;

    `TFDS_ASSERT(a_total_bound, r_total <= MAX_CNT, "kept total beyond store depth")
    `TFDS_ASSERT_NEVER(a_rw_overlap, wr_en && rd_en && (wr_addr == rd_addr),
        "read and write of the same entry in one cycle")
    `TFDS_ASSERT_NEVER(a_emit_write, (r_state == ST_EMIT) && wr_en, "store written during readout")
    `TFDS_ASSERT(a_clear_after_last, (r_state == ST_EMIT) && load && n_out_last |=> (r_total == '0)
        && (r_state == ST_IDLE) && !r_ovf, "store not cleared after last result")

endmodule

### rtl/threshold_filter_descending_sort_core.sv
// top level of the threshold filter with stable descending sort
//
// input channel: one item per match count with its row and column index,
// accepted when i_in_valid is high and o_in_stall is low. an item whose count
// is at least the match limit is kept; at most MAX_ENTRIES are kept, further
// kept candidates are dropped and raise the overflow flag of the run.
// kept entries are inserted in sorted place as they arrive: any kept item
// but the first of a run or one that finds the store full goes through the
// insert state, which moves each stored entry with a smaller count up one
// place via the memory's single read and write port, and the place state at
// entry 0. on the item with final_entry set, the sorted list is read out
// from the emit state that follows, one result per cycle while the receiver
// does not stall; a stalled result holds, and while it waits an item stalls
// if the store is not empty or it ends a run. an empty run gives one result
// with entry_valid low and end_of_list high. the match limit is written
// through i_cfg_valid / o_cfg_ready; the user must write it only while idle,
// the block does not enforce it. reset empties the store, clears overflow
// and sets the match limit to 200; the memory itself is not cleared.

module threshold_filter_descending_sort_core import tfds_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned INDEX_BITS  = 8,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LIMIT_BITS-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COUNT_BITS-1:0] i_match_count,
    input  logic [INDEX_BITS-1:0] i_row_index,
    input  logic [INDEX_BITS-1:0] i_col_index,
    input  logic                  i_final_entry,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COUNT_BITS-1:0] o_out_count,
    output logic [INDEX_BITS-1:0] o_out_row,
    output logic [INDEX_BITS-1:0] o_out_col,
    output logic                  o_entry_valid,
    output logic                  o_overflowed,
    output logic                  o_end_of_list
);

    localparam int unsigned CMP_W = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    logic [LIMIT_BITS-1:0] r_match_limit;
    t_in_ctl               in_ctl;
    t_out_stat             out_stat;
    logic [COUNT_BITS-1:0] st_count;
    logic [INDEX_BITS-1:0] st_row;
    logic [INDEX_BITS-1:0] st_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_match_limit <= i_cfg_data;
        end
    end

    assign in_ctl = '{valid: i_in_valid,
                      keep: (CMP_W'(i_match_count) >= CMP_W'(r_match_limit)),
                      last: i_final_entry};

    tfds_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .INDEX_BITS  (INDEX_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (in_ctl),
        .i_count     (i_match_count),
        .i_row       (i_row_index),
        .i_col       (i_col_index),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_stat      (out_stat),
        .o_count     (st_count),
        .o_row       (st_row),
        .o_col       (st_col)
    );

    // empty result carries zero fields
    assign o_out_valid   = out_stat.valid;
    assign o_entry_valid = out_stat.entry_valid;
    assign o_overflowed  = out_stat.overflowed;
    assign o_end_of_list = out_stat.end_of_list;
    assign o_out_count   = out_stat.entry_valid ? st_count : '0;
    assign o_out_row     = out_stat.entry_valid ? st_row : '0;
    assign o_out_col     = out_stat.entry_valid ? st_col : '0;

endmodule
